// ----- rtl/core/rxtp_pkg.sv -----
// Shared types, codes and the digit decoder of the radix integer text parser.
`timescale 1ns / 1ps

package rxtp_pkg;

  localparam int NUMBER_W           = 64;
  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int RADIX_W            = 7;
  localparam int STATUS_W           = 2;
  localparam int SIZE_W             = 2;
  localparam int CHAR_W             = 8;
  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 7;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_DIGITS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SIGN  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_SIZE = 2'd2;

  // Result size codes.
  localparam logic [SIZE_W-1:0] SIZE_1B = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_2B = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_4B = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_8B = 2'd3;

  localparam logic [RADIX_W-1:0] RADIX_RESET       = 7'd10;
  localparam logic               SIGNED_MODE_RESET = 1'b1;
  localparam logic [SIZE_W-1:0]  RESULT_SIZE_RESET = SIZE_4B;

  localparam logic [RADIX_W-1:0] RADIX_MIN        = 7'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX        = 7'd64;
  localparam logic [RADIX_W-1:0] RADIX_CASE_SPLIT = 7'd36;
  localparam logic [RADIX_W-1:0] DIGIT_NONE       = 7'd64;
  localparam logic [RADIX_W-1:0] DIGIT_SLASH      = 7'd62;
  localparam logic [RADIX_W-1:0] DIGIT_QUERY      = 7'd63;
  localparam logic [RADIX_W-1:0] UPPER_OFFSET     = 7'd26;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUMBER_W-1:0] number;
    logic                char_returned;
  } result_t;

  // Digit value of a character; DIGIT_NONE when it is no digit at all.
  // Upper case letters follow the lower case ones when the base is 36 or more.
  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c,
                                                  input logic upper_high);
    logic [RADIX_W-1:0] d;
    d = DIGIT_NONE;
    if (c inside {["0":"9"]}) begin
      d = RADIX_W'(c - 8'h30);
    end else if (c inside {["a":"z"]}) begin
      d = RADIX_W'(c - 8'h61) + 7'd10;
    end else if (c inside {["A":"Z"]}) begin
      d = RADIX_W'(c - 8'h41) + 7'd10 + (upper_high ? UPPER_OFFSET : 7'd0);
    end else if (c == 8'h2F) begin
      d = DIGIT_SLASH;
    end else if (c == 8'h3F) begin
      d = DIGIT_QUERY;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/radix_integer_text_parser.sv -----
// Top level of the radix integer text parser: decode, accumulate and result buffer.
`timescale 1ns / 1ps

// The parser takes one character item per clock cycle while in_ready is high, and
// builds an integer in the configured base. A character that ends the number, or an
// end-of-input item, produces one result item (any item does while the base is out
// of range), registered into the output register or, while that stalls, the skid
// entry. The cycle time is set by the single accumulate step, a VALUE_BITS by 7-bit
// multiply followed by the digit add and the exact overflow test. Results pass
// through a two-entry buffer, so input items keep being accepted while one result
// waits to be taken; in_ready only drops when both entries are full. Configuration
// writes are taken at once and should only be made while the parser is idle.
module radix_integer_text_parser #(
  parameter int VALUE_BITS = rxtp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rxtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rxtp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rxtp_pkg::CHAR_W-1:0]      char_code,
  input  logic                             text_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rxtp_pkg::STATUS_W-1:0]    status,
  output logic [rxtp_pkg::NUMBER_W-1:0]    number,
  output logic                             char_returned
);
  import rxtp_pkg::*;

  localparam int PROD_W = VALUE_BITS + RADIX_W;

  logic [RADIX_W-1:0] radix;
  logic               signed_mode;
  logic [SIZE_W-1:0]  result_size;

  logic [VALUE_BITS-1:0] accumulator, accumulator_next;
  logic                  negative, negative_next;
  logic                  seen_any, seen_any_next;
  logic                  seen_digit, seen_digit_next;

  result_t result_reg, skid;
  logic    skid_valid;

  logic               in_fire, out_take, produce;
  logic               radix_bad;
  logic [RADIX_W-1:0] digit;
  logic [PROD_W-1:0]  product;
  logic [PROD_W:0]    sum;
  logic               overflow;
  logic [NUMBER_W-1:0] magnitude, signed_value;
  result_t            fresh, finished;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;

  assign status        = result_reg.status;
  assign number        = result_reg.number;
  assign char_returned = result_reg.char_returned;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      signed_mode <= SIGNED_MODE_RESET;
      result_size <= RESULT_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIX:       radix       <= cfg_data;
        CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        CFG_RESULT_SIZE: result_size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign digit     = digit_of(char_code, radix >= RADIX_CASE_SPLIT);
  assign product   = PROD_W'(accumulator) * PROD_W'(radix);
  assign sum       = (PROD_W + 1)'(product) + (PROD_W + 1)'(digit);
  assign overflow  = |sum[PROD_W:VALUE_BITS];

  // Value of the number ended here, negated in 64 bits and cut to the result size.
  always_comb begin
    magnitude    = NUMBER_W'(accumulator);
    signed_value = negative ? (64'd0 - magnitude) : magnitude;
    case (result_size)
      SIZE_1B: signed_value = {56'd0, signed_value[7:0]};
      SIZE_2B: signed_value = {48'd0, signed_value[15:0]};
      SIZE_4B: signed_value = {32'd0, signed_value[31:0]};
      default: ;
    endcase
    finished.status        = seen_digit ? STATUS_OK : STATUS_NO_DIGITS;
    finished.number        = seen_digit ? signed_value : 64'd0;
    finished.char_returned = !text_end;
  end

  always_comb begin
    accumulator_next = accumulator;
    negative_next    = negative;
    seen_any_next    = seen_any;
    seen_digit_next  = seen_digit;
    produce          = 1'b0;
    fresh            = finished;

    if (radix_bad) begin
      produce                = 1'b1;
      fresh.status           = STATUS_NO_DIGITS;
      fresh.number           = 64'd0;
      fresh.char_returned    = !text_end;
    end else if (text_end) begin
      produce = 1'b1;
    end else if (char_code == CHAR_MINUS || char_code == CHAR_PLUS) begin
      if (seen_any) begin
        produce = 1'b1;
      end else if (char_code == CHAR_PLUS || signed_mode) begin
        negative_next = (char_code == CHAR_MINUS);
        seen_any_next = 1'b1;
      end else begin
        produce             = 1'b1;
        fresh.status        = STATUS_BAD_SIGN;
        fresh.number        = 64'd0;
        fresh.char_returned = 1'b0;
      end
    end else if (digit >= radix) begin
      produce = 1'b1;
    end else if (overflow) begin
      produce             = 1'b1;
      fresh.status        = STATUS_OVERFLOW;
      fresh.number        = 64'd0;
      fresh.char_returned = 1'b0;
    end else begin
      accumulator_next = sum[VALUE_BITS-1:0];
      seen_digit_next  = 1'b1;
      seen_any_next    = 1'b1;
    end

    // Every result starts the next number afresh.
    if (produce) begin
      accumulator_next = '0;
      negative_next    = 1'b0;
      seen_any_next    = 1'b0;
      seen_digit_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      negative    <= 1'b0;
      seen_any    <= 1'b0;
      seen_digit  <= 1'b0;
    end else if (in_fire) begin
      accumulator <= accumulator_next;
      negative    <= negative_next;
      seen_any    <= seen_any_next;
      seen_digit  <= seen_digit_next;
    end
  end

  // Two-entry result buffer: the output register, with a skid entry behind it
  // that fills only while the output item is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_fire && produce;
      end else begin
        out_valid  <= in_fire && produce;
      end
    end else if (in_fire && produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        result_reg <= skid;
        skid       <= fresh;
      end else begin
        result_reg <= fresh;
      end
    end else if (in_fire && produce) begin
      skid <= fresh;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the radix integer text parser, with a predictor and random stalls.
`timescale 1ns / 1ps

module testbench;
  import rxtp_pkg::*;

  localparam int LATENCY_WAIT   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int TARGET_ITEMS   = 1450;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0]      CHAR_SLASH = "/";
  localparam logic [CHAR_W-1:0]      CHAR_QUERY = "?";
  localparam logic [CHAR_W-1:0]      CHAR_SPACE = " ";

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CHAR_W-1:0]      char_code = '0;
  logic                   text_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [NUMBER_W-1:0]    number;
  logic                   char_returned;

  // Predictor copy of the configuration and of the parse state.
  logic [RADIX_W-1:0]  cfg_radix = RADIX_RESET;
  logic                cfg_signed = SIGNED_MODE_RESET;
  logic [SIZE_W-1:0]   cfg_size = RESULT_SIZE_RESET;
  logic [NUMBER_W-1:0] magnitude = '0;
  logic                negative = 1'b0;
  logic                any_taken = 1'b0;
  logic                digit_taken = 1'b0;

  char_item_t char_queue[$];
  result_t    parse_results_due[$];
  char_item_t next_item;

  int items_queued = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;
  bit long_hold_done = 1'b0;

  radix_integer_text_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .text_end     (text_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .number       (number),
    .char_returned(char_returned)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input int pct);
    if (int'($urandom_range(0, 99)) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 40));
    return int'($urandom_range(1, 3));
  endfunction

  function automatic int idle_choice();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] char_value(input logic [CHAR_W-1:0] ch);
    if (ch >= "0" && ch <= "9") return RADIX_W'(ch - "0");
    if (ch >= "a" && ch <= "z") return RADIX_W'(ch - "a") + 7'd10;
    if (ch >= "A" && ch <= "Z") begin
      return RADIX_W'(ch - "A") + 7'd10 + (cfg_radix >= RADIX_CASE_SPLIT ? UPPER_OFFSET : 7'd0);
    end
    if (ch == CHAR_SLASH) return DIGIT_SLASH;
    if (ch == CHAR_QUERY) return DIGIT_QUERY;
    return DIGIT_NONE;
  endfunction

  task automatic close_number(input logic [STATUS_W-1:0] st, input logic [NUMBER_W-1:0] num,
                              input logic ret);
    result_t r;
    r.status        = st;
    r.number        = num;
    r.char_returned = ret;
    parse_results_due.push_back(r);
    magnitude   = '0;
    negative    = 1'b0;
    any_taken   = 1'b0;
    digit_taken = 1'b0;
  endtask

  task automatic finish_number(input logic ret);
    logic [NUMBER_W-1:0] v;
    if (!digit_taken) begin
      close_number(STATUS_NO_DIGITS, '0, ret);
    end else begin
      v = negative ? 64'd0 - magnitude : magnitude;
      case (cfg_size)
        SIZE_1B: v = {56'd0, v[7:0]};
        SIZE_2B: v = {48'd0, v[15:0]};
        SIZE_4B: v = {32'd0, v[31:0]};
        default: ;
      endcase
      close_number(STATUS_OK, v, ret);
    end
  endtask

  // Advances the predicted parse state by one accepted item.
  task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic last);
    logic [RADIX_W-1:0] d;
    logic [71:0]        wide;
    items_accepted++;
    if (cfg_radix < RADIX_MIN || cfg_radix > RADIX_MAX) begin
      close_number(STATUS_NO_DIGITS, '0, !last);
    end else if (last) begin
      finish_number(1'b0);
    end else if (ch == CHAR_MINUS || ch == CHAR_PLUS) begin
      if (any_taken) begin
        finish_number(1'b1);
      end else if (ch == CHAR_PLUS || cfg_signed) begin
        negative  = (ch == CHAR_MINUS);
        any_taken = 1'b1;
      end else begin
        close_number(STATUS_BAD_SIGN, '0, 1'b0);
      end
    end else begin
      d = char_value(ch);
      if (d >= cfg_radix) begin
        finish_number(1'b1);
      end else begin
        // Widened product, so that the overflow test is exact.
        wide = 72'(magnitude) * cfg_radix + d;
        if (wide[71:64] != '0) begin
          close_number(STATUS_OVERFLOW, '0, 1'b0);
        end else begin
          magnitude   = wide[63:0];
          digit_taken = 1'b1;
          any_taken   = 1'b1;
        end
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    if (parse_results_due.size() == 0) begin
      $error("result item with none expected: status %0d number %h char_returned %0b",
             status, number, char_returned);
      mismatches++;
    end else begin
      want = parse_results_due.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (number !== want.number) begin
        $error("number: expected %h, got %h", want.number, number);
        mismatches++;
      end
      if (char_returned !== want.char_returned) begin
        $error("char_returned: expected %0b, got %0b", want.char_returned, char_returned);
        mismatches++;
      end
    end
  endtask

  // Sender: takes items from the queue, with random gaps after each one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(char_code, text_end);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          next_item = char_queue.pop_front();
          in_valid     <= 1'b1;
          char_code    <= next_item.code;
          text_end     <= next_item.last;
          send_gap = pick_gap(send_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks results and stalls at random, once for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        results_seen++;
      end
      if (!long_hold_done && results_seen >= 60 && char_queue.size() > 20) begin
        recv_hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (recv_hold > 0) begin
        recv_hold = recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        recv_hold = pick_gap(recv_idle_pct);
        if (recv_hold > 0) recv_hold = recv_hold - 1;
        out_ready <= (recv_hold == 0) && (pick_gap(recv_idle_pct) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic add_char(input logic [CHAR_W-1:0] ch);
    char_item_t it;
    it.code = ch;
    it.last = 1'b0;
    char_queue.push_back(it);
    items_queued++;
  endtask

  task automatic add_end();
    char_item_t it;
    it.code = CHAR_W'($urandom_range(0, 255));
    it.last = 1'b1;
    char_queue.push_back(it);
    items_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] v);
    if (v < 10) return "0" + CHAR_W'(v);
    if (v < RADIX_CASE_SPLIT) begin
      // Below base 36 both letter cases carry the same value.
      if (cfg_radix < RADIX_CASE_SPLIT && $urandom_range(0, 1)) return "A" + CHAR_W'(v - 10);
      return "a" + CHAR_W'(v - 10);
    end
    if (v < DIGIT_SLASH) return "A" + CHAR_W'(v - RADIX_CASE_SPLIT);
    if (v == DIGIT_SLASH) return CHAR_SLASH;
    return CHAR_QUERY;
  endfunction

  function automatic int max_digits(input logic [RADIX_W-1:0] rdx);
    logic [NUMBER_W-1:0] m;
    int n;
    m = '1;
    n = 0;
    while (m != 0) begin
      m = m / rdx;
      n++;
    end
    return n;
  endfunction

  // Mostly well-formed numbers with random content, the rest random bytes.
  task automatic add_random_number();
    int pick;
    int digit_count;
    logic [RADIX_W-1:0] v;
    if (cfg_radix < RADIX_MIN || cfg_radix > RADIX_MAX || $urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 6) == 0) add_end();
        else add_char(CHAR_W'($urandom_range(0, 255)));
      end
    end else begin
      pick = int'($urandom_range(0, 9));
      if (pick < 3) add_char(CHAR_MINUS);
      else if (pick < 5) add_char(CHAR_PLUS);
      pick = int'($urandom_range(0, 9));
      if (pick == 0) digit_count = 0;
      else if (pick < 7) digit_count = int'($urandom_range(1, 5));
      else digit_count = max_digits(cfg_radix) + int'($urandom_range(0, 2)) - 1;
      repeat (digit_count) add_char(digit_char(RADIX_W'($urandom_range(0, cfg_radix - 1))));
      pick = int'($urandom_range(0, 9));
      if (pick < 4) begin
        add_end();
      end else if (pick < 6) begin
        add_char(CHAR_W'($urandom_range(0, 255)));
      end else if (pick < 8) begin
        add_char(pick[0] ? CHAR_MINUS : CHAR_PLUS);
      end else if (cfg_radix < RADIX_MAX) begin
        v = RADIX_W'($urandom_range(cfg_radix, 63));
        if (cfg_radix < RADIX_CASE_SPLIT && v >= RADIX_CASE_SPLIT && v < DIGIT_SLASH) begin
          v = RADIX_CASE_SPLIT - 1;
        end
        add_char(digit_char(v));
      end else begin
        add_char(CHAR_SPACE);
      end
    end
  endtask

  task automatic fill(input int n);
    int goal;
    goal = items_queued + n;
    while (items_queued < goal) add_random_number();
  endtask

  // Returns once every item is taken, every result checked and the pipeline has emptied.
  task automatic drain();
    do @(posedge clk);
    while (items_accepted != items_queued || parse_results_due.size() != 0);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_RADIX:       cfg_radix = data;
      CFG_SIGNED_MODE: cfg_signed = data[0];
      CFG_RESULT_SIZE: cfg_size = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [RADIX_W-1:0] rdx, input logic sgn,
                           input logic [SIZE_W-1:0] sz, input int n,
                           input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_reg(CFG_RADIX, rdx);
    set_reg(CFG_SIGNED_MODE, {6'($urandom_range(0, 63)), sgn});
    set_reg(CFG_RESULT_SIZE, {5'($urandom_range(0, 31)), sz});
    cfg_valid <= 1'b0;
    fill(n);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Settings straight out of reset: base 10, signed, four byte results.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    add_text("-7");
    add_end();
    add_text("+");
    add_end();
    add_end();
    add_text("4-");
    add_text("9a");
    add_text("+-");
    add_text("Z");
    add_char(8'hFF);
    add_char(8'h00);
    add_text("0");
    add_end();
    fill(130);
    drain();

    run_phase(7'd2, 1'b0, SIZE_1B, 150, 0, 0);
    set_reg(CFG_UNUSED, 7'h55);
    run_phase(RADIX_MAX, 1'b1, SIZE_8B, 150, 45, 15);
    run_phase(7'd16, 1'b1, SIZE_2B, 150, 15, 45);
    run_phase(RADIX_CASE_SPLIT, 1'b0, SIZE_8B, 120, idle_choice(), idle_choice());
    run_phase(7'd35, 1'b1, SIZE_4B, 120, idle_choice(), idle_choice());
    // Bases outside the legal range reject every item.
    run_phase(7'd1, 1'b1, SIZE_4B, 25, idle_choice(), idle_choice());
    run_phase(7'd65, 1'b0, SIZE_1B, 25, idle_choice(), idle_choice());
    run_phase(7'd0, 1'b1, SIZE_8B, 15, idle_choice(), idle_choice());
    run_phase(7'd127, 1'b0, SIZE_2B, 15, idle_choice(), idle_choice());
    while (items_queued < TARGET_ITEMS) begin
      run_phase(RADIX_W'($urandom_range(2, 64)), 1'($urandom_range(0, 1)),
                SIZE_W'($urandom_range(0, 3)), 120, idle_choice(), idle_choice());
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- radix_integer_text_parser.f -----
rtl/core/rxtp_pkg.sv
rtl/core/radix_integer_text_parser.sv
bench/testbench.sv
